@@ hdl/cs_pkg.sv @@
// Shared types and character codes for the comment stripper.
package cs_pkg;

    localparam int CHAR_W  = 21;
    localparam int START_W = 32;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    localparam logic [CHAR_W-1:0] CH_NL    = 21'h0000A;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 21'h00022;
    localparam logic [CHAR_W-1:0] CH_SLASH = 21'h0002F;
    localparam logic [CHAR_W-1:0] CH_STAR  = 21'h0002A;
    localparam logic [CHAR_W-1:0] CH_SPACE = 21'h00020;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OPEN_BLK  = 2'd1;
    localparam logic [1:0] ST_OPEN_STR  = 2'd2;

    typedef struct packed {
        logic              cmd;
        logic [CHAR_W-1:0] char_in;
    } item_t;

    typedef struct packed {
        logic               has_char;
        logic [CHAR_W-1:0]  char_out;
        logic               is_last;
        logic [1:0]         status;
        logic [START_W-1:0] start_line;
    } result_t;

    // Each bundle that the front end pushes gives one or two results.
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } bundle_t;

    function automatic result_t char_result(input logic [CHAR_W-1:0] c);
        result_t r;
        r            = '0;
        r.has_char   = 1'b1;
        r.char_out   = c;
        return r;
    endfunction

endpackage

@@ hdl/comment_stripper.sv @@
// Top level of the comment stripper: front end, bundle queue, back end.
//
// Input channel (item_valid / item_stall / item): one word per character,
// cmd = 0 with the code point in char_in, then one word with cmd = 1 to end
// the text. Output channel (result_valid / result_stall / result): kept or
// substituted characters (has_char = 1), and after the end word one status
// word (is_last = 1) giving ok, open block comment or open string, with
// the line on which it opened. A word may give zero, one or two results.
// Path: a result goes from the taken input word into the bundle queue,
// then into the output register, from which it can leave; the second
// result of a word follows the first through the output register.
// Throughput: one input word per cycle unless the queue is full; words
// that give two results (held slash followed by a character, block
// comment opening, held slash at end) leave as two output words, which
// the four-entry queue absorbs. item_stall rises only when that queue
// is full; result_stall holds the output register and the queue fills
// behind it. Reset: plain-text mode, line counter at 1, queue and output
// empty. After every end word the front end returns to the same values.
module comment_stripper #(
    parameter int LINE_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  cs_pkg::item_t   item,
    output logic            result_valid,
    input  logic            result_stall,
    output cs_pkg::result_t result
);

    logic            push;
    cs_pkg::bundle_t bundle;
    logic            q_full;
    logic            pop;
    logic            head_valid;
    cs_pkg::bundle_t head;

    assign item_stall = q_full;

    // classification and line tracking
    cs_front #(
        .LINE_BITS (LINE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .q_full     (q_full),
        .push       (push),
        .bundle     (bundle)
    );

    cs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (bundle),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // serialises bundles onto the output register
    cs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ hdl/cs_front.sv @@
// Front end: takes input words, tracks comment state, builds result bundles.
module cs_front #(
    parameter int LINE_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  cs_pkg::item_t    item,
    input  logic             q_full,
    output logic             push,
    output cs_pkg::bundle_t  bundle
);

    typedef enum logic [1:0] {
        M_PLAIN,
        M_LINE,
        M_BLOCK,
        M_STRING
    } mode_t;

    mode_t                mode_reg, mode_next;
    logic                 slash_held_reg, slash_held_next;
    logic                 star_seen_reg, star_seen_next;
    logic [LINE_BITS-1:0] line_count_reg, line_count_next;
    logic [LINE_BITS-1:0] open_line_reg, open_line_next;

    logic                 take;
    logic [cs_pkg::CHAR_W-1:0] c;
    logic [LINE_BITS-1:0] line_bumped;
    logic                 open_hi;
    logic [cs_pkg::START_W-1:0] open_sat;
    cs_pkg::result_t      stat_res;

    assign take = item_valid && !q_full;
    assign c    = item.char_in;

    // saturating line counter
    assign line_bumped = (line_count_reg == {LINE_BITS{1'b1}}) ? line_count_reg
                                                               : line_count_reg + 1'b1;

    // start line clipped to the 32-bit field
    assign open_hi  = (LINE_BITS > cs_pkg::START_W) ? |(open_line_reg >> cs_pkg::START_W)
                                                    : 1'b0;
    assign open_sat = open_hi ? {cs_pkg::START_W{1'b1}}
                              : cs_pkg::START_W'(open_line_reg);

    always_comb
    begin
        stat_res         = '0;
        stat_res.is_last = 1'b1;
        case (mode_reg)
            M_BLOCK:
            begin
                stat_res.status     = cs_pkg::ST_OPEN_BLK;
                stat_res.start_line = open_sat;
            end
            M_STRING:
            begin
                stat_res.status     = cs_pkg::ST_OPEN_STR;
                stat_res.start_line = open_sat;
            end
            default:
            begin
                stat_res.status = cs_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        mode_next       = mode_reg;
        slash_held_next = slash_held_reg;
        star_seen_next  = star_seen_reg;
        line_count_next = line_count_reg;
        open_line_next  = open_line_reg;
        push            = 1'b0;
        bundle          = '0;

        if (take)
        begin
            if (item.cmd == cs_pkg::CMD_END)
            begin
                push = 1'b1;
                if (slash_held_reg)
                begin
                    bundle.two = 1'b1;
                    bundle.r0  = cs_pkg::char_result(cs_pkg::CH_SLASH);
                    bundle.r1  = stat_res;
                end
                else
                begin
                    bundle.r0 = stat_res;
                end
                mode_next       = M_PLAIN;
                slash_held_next = 1'b0;
                star_seen_next  = 1'b0;
                line_count_next = LINE_BITS'(1);
                open_line_next  = '0;
            end
            else
            begin
                case (mode_reg)
                    M_PLAIN:
                    begin
                        if (slash_held_reg && c == cs_pkg::CH_SLASH)
                        begin
                            slash_held_next = 1'b0;
                            mode_next       = M_LINE;
                        end
                        else if (slash_held_reg && c == cs_pkg::CH_STAR)
                        begin
                            slash_held_next = 1'b0;
                            mode_next       = M_BLOCK;
                            star_seen_next  = 1'b0;
                            open_line_next  = line_count_reg;
                            push            = 1'b1;
                            bundle.two      = 1'b1;
                            bundle.r0       = cs_pkg::char_result(cs_pkg::CH_SPACE);
                            bundle.r1       = cs_pkg::char_result(cs_pkg::CH_SPACE);
                        end
                        else if (c == cs_pkg::CH_SLASH)
                        begin
                            // new slash held; any old held slash goes out now
                            slash_held_next = 1'b1;
                            push            = slash_held_reg;
                            bundle.r0       = cs_pkg::char_result(cs_pkg::CH_SLASH);
                        end
                        else
                        begin
                            slash_held_next = 1'b0;
                            push            = 1'b1;
                            if (c == cs_pkg::CH_QUOTE)
                            begin
                                mode_next      = M_STRING;
                                open_line_next = line_count_reg;
                            end
                            else if (c == cs_pkg::CH_NL)
                            begin
                                line_count_next = line_bumped;
                            end
                            if (slash_held_reg)
                            begin
                                bundle.two = 1'b1;
                                bundle.r0  = cs_pkg::char_result(cs_pkg::CH_SLASH);
                                bundle.r1  = cs_pkg::char_result(c);
                            end
                            else
                            begin
                                bundle.r0 = cs_pkg::char_result(c);
                            end
                        end
                    end
                    M_LINE:
                    begin
                        if (c == cs_pkg::CH_NL)
                        begin
                            line_count_next = line_bumped;
                            mode_next       = M_PLAIN;
                            push            = 1'b1;
                            bundle.r0       = cs_pkg::char_result(c);
                        end
                    end
                    M_BLOCK:
                    begin
                        push = 1'b1;
                        if (c == cs_pkg::CH_NL)
                        begin
                            line_count_next = line_bumped;
                            star_seen_next  = 1'b0;
                            bundle.r0       = cs_pkg::char_result(c);
                        end
                        else
                        begin
                            if (star_seen_reg && c == cs_pkg::CH_SLASH)
                            begin
                                mode_next      = M_PLAIN;
                                star_seen_next = 1'b0;
                            end
                            else
                            begin
                                star_seen_next = (c == cs_pkg::CH_STAR);
                            end
                            bundle.r0 = cs_pkg::char_result(cs_pkg::CH_SPACE);
                        end
                    end
                    default:
                    begin
                        push = 1'b1;
                        if (c == cs_pkg::CH_QUOTE)
                        begin
                            mode_next = M_PLAIN;
                        end
                        else if (c == cs_pkg::CH_NL)
                        begin
                            line_count_next = line_bumped;
                        end
                        bundle.r0 = cs_pkg::char_result(c);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= M_PLAIN;
            slash_held_reg <= 1'b0;
            star_seen_reg  <= 1'b0;
            line_count_reg <= LINE_BITS'(1);
            open_line_reg  <= '0;
        end
        else
        begin
            mode_reg       <= mode_next;
            slash_held_reg <= slash_held_next;
            star_seen_reg  <= star_seen_next;
            line_count_reg <= line_count_next;
            open_line_reg  <= open_line_next;
        end
    end

endmodule

@@ hdl/cs_queue.sv @@
// Short bundle queue between front and back ends.
module cs_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cs_pkg::bundle_t  push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output cs_pkg::bundle_t  head
);

    localparam int CNT_W = cs_pkg::Q_PTR_W + 1;

    cs_pkg::bundle_t             mem_reg [cs_pkg::Q_DEPTH];
    logic [cs_pkg::Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [cs_pkg::Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        do_push, do_pop;

    assign full       = (count_reg == CNT_W'(cs_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/cs_back.sv @@
// Back end: splits bundles into single results and holds the output register.
module cs_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  cs_pkg::bundle_t  head,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_stall,
    output cs_pkg::result_t  result
);

    logic            out_valid_reg, out_valid_next;
    cs_pkg::result_t out_reg, out_next;
    logic            half_reg, half_next;
    logic            load;

    assign load = !out_valid_reg || !result_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        half_next      = half_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                out_next = half_reg ? head.r1 : head.r0;
                if (half_reg || !head.two)
                begin
                    pop       = 1'b1;
                    half_next = 1'b0;
                end
                else
                begin
                    half_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            half_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

@@ hdl/cs_checker.sv @@
// Port-level checks for the comment stripper, bound to the top level.
module cs_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            result_valid,
    input logic            result_stall,
    input cs_pkg::result_t result
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result word dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result word changed while stalled");

    a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_last |-> !result.has_char && result.char_out == '0)
        else $error("status word carries a character");

    a_char_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.is_last |->
            result.has_char && result.status == cs_pkg::ST_OK && result.start_line == '0)
        else $error("character word carries status");

endmodule

bind comment_stripper cs_checker u_cs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
